### sv/smd_pkg.sv
package smd_pkg;
  localparam int DefDataWidth = 64;
  localparam int FieldWidth = 64;

  // control carried with every pipelined request
  typedef struct packed {
    logic neg;
    logic dz;
    logic zero;
  } smd_ctl_t;
endpackage

### sv/smd_mul.sv
// magnitude and full product, two register stages, 32x32 partial products
module smd_mul import smd_pkg::*; #(
  parameter int DW = DefDataWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     a,
  input  logic [DW-1:0]     b,
  input  logic [DW-1:0]     c,
  output logic              out_valid,
  output logic [2*DW-1:0]   prod,
  output logic [DW-1:0]     mc,
  output smd_ctl_t          ctl
);
  localparam int HW = (DW + 1) / 2;

  logic [DW-1:0] ma, mb, mc_in;
  logic [HW-1:0] al, ah, bl, bh;
  logic [2*HW-1:0] ll, lh, hl, hh;
  logic [DW-1:0] mc1;
  smd_ctl_t ctl1, ctl_in;
  logic v1;

  // magnitudes of the request operands
  always_comb begin
    ma = a[DW-1] ? (~a + 1'b1) : a;
    mb = b[DW-1] ? (~b + 1'b1) : b;
    mc_in = c[DW-1] ? (~c + 1'b1) : c;
    {ah, al} = {{(2*HW-DW){1'b0}}, ma};
    {bh, bl} = {{(2*HW-DW){1'b0}}, mb};
    ctl_in.neg = a[DW-1] ^ b[DW-1] ^ c[DW-1];
    ctl_in.dz = (c == '0);
    ctl_in.zero = (a == '0) || (b == '0);
  end

  // stage one: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ll <= al * bl;
      lh <= al * bh;
      hl <= ah * bl;
      hh <= ah * bh;
      mc1 <= mc_in;
      ctl1 <= ctl_in;
    end
  end

  // stage two: sum partial products
  logic [4*HW-1:0] sum;
  always_comb begin
    sum = {{(2*HW){1'b0}}, ll} + ({{(2*HW){1'b0}}, lh} << HW)
        + ({{(2*HW){1'b0}}, hl} << HW) + {hh, {(2*HW){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      prod <= sum[2*DW-1:0];
      mc <= mc1;
      ctl <= ctl1;
    end
  end
endmodule

### sv/smd_div_stage.sv
// one registered division step group: STEPS quotient bits per stage
module smd_div_stage import smd_pkg::*; #(
  parameter int DW = DefDataWidth,
  parameter int STEPS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*DW-1:0] in_num,
  input  logic [DW:0]     in_rem,
  input  logic [DW-1:0]   in_d,
  input  smd_ctl_t        in_ctl,
  output logic            out_valid,
  output logic [2*DW-1:0] out_num,
  output logic [DW:0]     out_rem,
  output logic [DW-1:0]   out_d,
  output smd_ctl_t        out_ctl
);
  logic [2*DW-1:0] num;
  logic [DW:0] rem;
  logic [DW+1:0] trial;

  // restoring steps, quotient bits shift into the numerator register
  always_comb begin
    num = in_num;
    rem = in_rem;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem, num[2*DW-1]} - {2'b00, in_d};
      num = {num[2*DW-2:0], 1'b0};
      if (!trial[DW+1]) begin
        rem = trial[DW:0];
        num[0] = 1'b1;
      end else begin
        rem = trial[DW:0] + {1'b0, in_d};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_num <= num;
      out_rem <= rem;
      out_d <= in_d;
      out_ctl <= in_ctl;
    end
  end
endmodule

### sv/signed_muldiv_64.sv
// a request passes the multiplier stages, the divider stages and the output register in that order
// throughput: one request per cycle; a stall freezes the whole pipeline
// the divider is a chain of registered stages of four restoring steps each
// reset clears all valid bits; payload registers are not reset
module signed_muldiv_64 import smd_pkg::*; #(
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FieldWidth-1:0] operand_value,
  input  logic [FieldWidth-1:0] multiplier_value,
  input  logic [FieldWidth-1:0] divisor_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FieldWidth-1:0] scaled_result,
  output logic                  divide_by_zero,
  output logic                  quotient_overflow
);
  localparam int DW = DATA_WIDTH;
  localparam int STEPS = 4;
  localparam int NST = (2 * DW + STEPS - 1) / STEPS;
  localparam int PAD = NST * STEPS - 2 * DW;

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic m_valid;
  logic [2*DW-1:0] prod;
  logic [DW-1:0] mc;
  smd_ctl_t m_ctl;

  smd_mul #(.DW(DW)) u_mul (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .a(operand_value[DW-1:0]), .b(multiplier_value[DW-1:0]),
    .c(divisor_value[DW-1:0]),
    .out_valid(m_valid), .prod(prod), .mc(mc), .ctl(m_ctl)
  );

  // divider chain; numerator is padded so every stage does the same steps
  localparam int NW = 2 * DW + PAD;
  localparam int HNW = NW / 2;
  logic [NST:0] sv;
  logic [NW-1:0] snum [NST+1];
  logic [NW/2:0] srem [NST+1];
  logic [NW/2-1:0] sd [NST+1];
  smd_ctl_t sctl [NST+1];

  assign sv[0] = m_valid;
  assign snum[0] = {{PAD{1'b0}}, prod} << 0;
  assign srem[0] = '0;
  assign sd[0] = HNW'(mc);
  assign sctl[0] = m_ctl;

  for (genvar g = 0; g < NST; g++) begin : g_div
    smd_div_stage #(.DW(NW/2), .STEPS(STEPS)) u_st (
      .clk(clk), .rst(rst), .en(en), .in_valid(sv[g]),
      .in_num(snum[g]), .in_rem(srem[g]), .in_d(sd[g]), .in_ctl(sctl[g]),
      .out_valid(sv[g+1]), .out_num(snum[g+1]), .out_rem(srem[g+1]),
      .out_d(sd[g+1]), .out_ctl(sctl[g+1])
    );
  end

  // sign, flags and output register
  logic [NW-1:0] q;
  logic [DW-1:0] res;
  logic ovf;
  smd_ctl_t fc;
  always_comb begin
    q = snum[NST];
    fc = sctl[NST];
    ovf = (q[NW-1:DW] != '0);
    res = fc.neg ? (~q[DW-1:0] + 1'b1) : q[DW-1:0];
    if (fc.dz || fc.zero) begin
      res = '0;
      ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[NST];
    end
    if (en) begin
      scaled_result <= FieldWidth'($signed(res));
      divide_by_zero <= fc.dz;
      quotient_overflow <= ovf;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) |-> $stable(scaled_result))
    else $error("result changed under stall");
  // flags never both set
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(divide_by_zero && quotient_overflow))
    else $error("both flags set");
  // divide by zero gives zero result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (scaled_result == '0))
    else $error("nonzero result on divide by zero");
endmodule

### dv/tb_signed_muldiv_64.sv
`timescale 1ns / 1ps

module tb_signed_muldiv_64;
  import smd_pkg::*;

  localparam int Width = DefDataWidth;
  localparam int Latency = 2 + 2 * Width / 4 + 1;

  typedef struct packed {
    logic [FieldWidth-1:0] scaled;
    logic                  dz;
    logic                  ovf;
  } scaled_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FieldWidth-1:0] operand_value = '0;
  logic [FieldWidth-1:0] multiplier_value = '0;
  logic [FieldWidth-1:0] divisor_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FieldWidth-1:0] scaled_result;
  logic                  divide_by_zero;
  logic                  quotient_overflow;

  scaled_t expected_q[$];
  int      errors = 0;
  bit      sink_busy = 1'b1;

  signed_muldiv_64 u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_value(operand_value), .multiplier_value(multiplier_value),
    .divisor_value(divisor_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .scaled_result(scaled_result), .divide_by_zero(divide_by_zero),
    .quotient_overflow(quotient_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicts the scaled quotient for one request
  function automatic scaled_t predict_scaled(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] c);
    logic [Width-1:0]   aw, bw, cw, ma, mb, mc, low;
    logic [2*Width-1:0] prod, quot;
    logic               neg;
    scaled_t            r;
    aw = a[Width-1:0];
    bw = b[Width-1:0];
    cw = c[Width-1:0];
    neg = aw[Width-1] ^ bw[Width-1] ^ cw[Width-1];
    ma = aw[Width-1] ? -aw : aw;
    mb = bw[Width-1] ? -bw : bw;
    mc = cw[Width-1] ? -cw : cw;
    r = '0;
    if (mc == '0) begin
      r.dz = 1'b1;
      return r;
    end
    if (ma == '0 || mb == '0) return r;
    prod = {{Width{1'b0}}, ma} * {{Width{1'b0}}, mb};
    quot = prod / {{Width{1'b0}}, mc};
    r.ovf = |quot[2*Width-1:Width];
    low = quot[Width-1:0];
    if (neg) low = -low;
    r.scaled = {{(FieldWidth-Width){low[Width-1]}}, low};
    return r;
  endfunction

  // sends one request with a random gap before it
  task automatic send_request(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operand_value <= a;
    multiplier_value <= b;
    divisor_value <= c;
    expected_q.push_back(predict_scaled(a, b, c));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // random stall pattern on the result side
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!sink_busy) begin
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 13);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // checks each result against the oldest prediction
  always @(posedge clk) begin
    scaled_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", scaled_result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (scaled_result !== e.scaled) begin
          $error("scaled_result exp %h got %h", e.scaled, scaled_result);
          errors++;
        end
        if (divide_by_zero !== e.dz) begin
          $error("divide_by_zero exp %b got %b", e.dz, divide_by_zero);
          errors++;
        end
        if (quotient_overflow !== e.ovf) begin
          $error("quotient_overflow exp %b got %b", e.ovf, quotient_overflow);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // value with interesting magnitude: edges, small, or random width
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = 64'(int'($urandom_range(0, 8)) - 4);
      3: v = rand64() >> $urandom_range(0, 63);
      4: v = -(rand64() >> $urandom_range(0, 63));
      default: v = rand64();
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] mn, mx;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7FFF_FFFF_FFFF_FFFF;
    send_request(64'(5), 64'(7), 64'(0));
    send_request(mn, mn, 64'(0));
    send_request(64'(0), mx, 64'(3));
    send_request(mx, 64'(0), 64'(-3));
    send_request(mx, mx, 64'(1));
    send_request(mn, mn, mn);
    send_request(mn, 64'(1), 64'(1));
    send_request(mn, 64'(-1), 64'(1));
    send_request(mn, 64'(1), 64'(-1));
    send_request(mx, mx, mx);
    send_request(mn, mn, 64'(1));
    send_request(64'(-7), 64'(3), 64'(2));
    send_request(64'(7), 64'(-3), 64'(2));
    send_request(64'(-7), 64'(-3), 64'(-2));
    send_request(mx, 64'(2), 64'(1));
    send_request(mx, mx, 64'(2));
    send_request(64'(-1), 64'(-1), 64'(-1));
    send_request(rand64(), rand64(), rand64());
    send_request(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'(3));
  endtask

  task automatic test_random(int count);
    logic [63:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      a = pick_value();
      b = pick_value();
      c = pick_value();
      // in a quarter of requests use a large odd divisor so the quotient stays near range
      if ($urandom_range(0, 3) == 0) c = rand64() | 64'h1;
      send_request(a, b, c);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random(1250);
    wait_drained();
    sink_busy = 1'b0;
    repeat (Latency + 10) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule

### files.f
sv/smd_pkg.sv
sv/smd_mul.sv
sv/smd_div_stage.sv
sv/signed_muldiv_64.sv
dv/tb_signed_muldiv_64.sv
